@@ sv/table_cubic_lagrange_interp_core_defines.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the table cubic Lagrange interpolator
// Clocked concurrent checks on clk_i with reset masking; empty when disabled.
// ---------------------------------------------------------------------------
`ifndef TABLE_CUBIC_LAGRANGE_INTERP_CORE_DEFINES_SVH
`define TABLE_CUBIC_LAGRANGE_INTERP_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Plain clocked check of a property.
`define TCLI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Implication whose consequent is checked in the following cycle.
`define TCLI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);
`else
`define TCLI_ASSERT(lbl, prop, msg)
`define TCLI_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ sv/tcli_pkg.sv @@
// ---------------------------------------------------------------------------
// tcli_pkg
// Shared constants and types of the table cubic Lagrange interpolator.
// ---------------------------------------------------------------------------
package tcli_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int NUM_BANKS   = 4;
  localparam int BANK_SEL_W  = $clog2(NUM_BANKS);
  localparam int BANK_DEPTH  = TABLE_DEPTH / NUM_BANKS;
  localparam int ROW_W       = $clog2(BANK_DEPTH);
  localparam int PIPE_STAGES = 8;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_EVAL  = 1'b1;

  localparam logic        REG_INDEX_SCALE   = 1'b0;
  localparam logic [31:0] INDEX_SCALE_RESET = 32'd65536;

  // floor(x/3) = (x * DIV3_MUL) >> 31 for x below 2^30
  localparam logic [29:0] DIV3_MUL = 30'h2AAA_AAAB;

  typedef struct packed {
    logic valid;
    logic eval;
    logic oor;
  } ctrl_t;

endpackage

@@ sv/tcli_ram.sv @@
// ---------------------------------------------------------------------------
// tcli_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ---------------------------------------------------------------------------
module tcli_ram #(
  parameter int  WIDTH = 32,
  parameter int  DEPTH = 64,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old word on a same-address write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

@@ sv/table_cubic_lagrange_interp_core.sv @@
// ---------------------------------------------------------------------------
// table_cubic_lagrange_interp_core
// Four-point Lagrange interpolation over a 256-entry Q4.28 sample table.
// ---------------------------------------------------------------------------
// Every request, writes too, passes the control pipeline ctrl_q and the output register.
// Throughput: one request per cycle unless the output stalls; the four sample
//   reads of an evaluate come from four RAM banks (entry index mod 4), one read port each.
// Reset: clears index_scale to 1.0 and all pipeline valids; the table RAM
//   is not cleared and an entry holds garbage until written.
`include "table_cubic_lagrange_interp_core_defines.svh"

module table_cubic_lagrange_interp_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  // request stream
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [71:0]                  s_tdata,  // entry_index, entry_value, distance
  input  logic [0:0]                   s_tuser,  // cmd
  // result stream
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [31:0]                  m_tdata,  // value
  output logic [0:0]                   m_tuser   // out_of_range
);

  import tcli_pkg::*;

  // ---------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------
  logic [31:0] index_scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      index_scale_q <= INDEX_SCALE_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_INDEX_SCALE)) begin
      index_scale_q <= pwdata;
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_INDEX_SCALE) ? index_scale_q : 32'd0;

  // ---------------------------------------------------------------------
  // Request unpacking and global pipeline enable
  // ---------------------------------------------------------------------
  logic                     cmd;
  logic [7:0]               entry_index;
  logic [31:0]              entry_value;
  logic [31:0]              distance;
  logic                     en;
  logic                     accept;
  logic                     out_valid_q;

  assign cmd         = s_tuser[0];
  assign entry_index = s_tdata[7:0];
  assign entry_value = s_tdata[39:8];
  assign distance    = s_tdata[71:40];

  // whole pipeline advances whenever the output register can take a result
  assign en       = !out_valid_q || m_tready;
  assign s_tready = en;
  assign accept   = s_tvalid && en;

  // ---------------------------------------------------------------------
  // Control pipeline
  // ---------------------------------------------------------------------
  ctrl_t ctrl_q [PIPE_STAGES];
  logic  [PIPE_STAGES-1:0] pipe_vld;
  logic  oor_s1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PIPE_STAGES; i++) begin
        ctrl_q[i] <= '0;
      end
      out_valid_q <= 1'b0;
    end else if (en) begin
      ctrl_q[0] <= '{valid: accept, eval: (cmd == CMD_EVAL), oor: 1'b0};
      ctrl_q[1] <= '{valid: ctrl_q[0].valid, eval: ctrl_q[0].eval,
                     oor: ctrl_q[0].eval && oor_s1};
      for (int i = 2; i < PIPE_STAGES; i++) begin
        ctrl_q[i] <= ctrl_q[i-1];
      end
      out_valid_q <= ctrl_q[PIPE_STAGES-1].valid;
    end
  end

  always_comb begin
    for (int i = 0; i < PIPE_STAGES; i++) begin
      pipe_vld[i] = ctrl_q[i].valid;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: table position = distance * index_scale (Q32.32)
  // ---------------------------------------------------------------------
  logic [63:0] pos_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      pos_q <= distance * index_scale_q;
    end
  end

  // stencil base..base+3 must stay inside the table
  assign oor_s1 = (pos_q[63:32] > 32'(TABLE_DEPTH - 4));

  // ---------------------------------------------------------------------
  // Banked sample table: entry e lives in bank e mod 4, row e / 4.
  // Writes go in at accept, evaluates read from the registered position pos_q, so
  // the RAM's old-data read on a same-address write keeps request order.
  // ---------------------------------------------------------------------
  logic [31:0]          rdata [NUM_BANKS];
  logic [NUM_BANKS-1:0] bank_we;

  for (genvar bk = 0; bk < NUM_BANKS; bk++) begin : g_bank
    logic [ROW_W-1:0] raddr;

    // banks below the base's low bits hold the stencil's tail in the next row
    assign raddr = pos_q[32+BANK_SEL_W +: ROW_W]
                 + ROW_W'(pos_q[32 +: BANK_SEL_W] > BANK_SEL_W'(bk));
    assign bank_we[bk] = accept && (cmd == CMD_WRITE)
                       && (entry_index[BANK_SEL_W-1:0] == BANK_SEL_W'(bk));

    tcli_ram #(
      .WIDTH (32),
      .DEPTH (BANK_DEPTH)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (bank_we[bk]),
      .waddr_i (entry_index[BANK_SEL_W +: ROW_W]),
      .wdata_i (entry_value),
      .re_i    (en),
      .raddr_i (raddr),
      .rdata_o (rdata[bk])
    );
  end

  // ---------------------------------------------------------------------
  // Stage 2: pairwise products of the weight factors
  //   a = u+1, b = u, c = u-1, d = u-2 (u in units of 2^-16)
  // ---------------------------------------------------------------------
  logic [15:0]           u_s1;
  logic signed [17:0]    fa, fb, fc, fd;
  logic signed [35:0]    bc_q, ac_q, ab_q;
  logic signed [17:0]    c2_q, d2_q;
  logic [BANK_SEL_W-1:0] base_lo2_q;

  assign u_s1 = pos_q[31:16];
  assign fa   = {2'b01, u_s1};
  assign fb   = {2'b00, u_s1};
  assign fc   = {2'b11, u_s1};
  assign fd   = {2'b10, u_s1};

  always_ff @(posedge clk_i) begin
    if (en) begin
      bc_q       <= fb * fc;
      ac_q       <= fa * fc;
      ab_q       <= fa * fb;
      c2_q       <= fc;
      d2_q       <= fd;
      base_lo2_q <= pos_q[32 +: BANK_SEL_W];
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: cubic numerators; rotate bank data into stencil order
  // ---------------------------------------------------------------------
  logic signed [53:0] n_q  [4];
  logic        [31:0] e3_q [4];

  always_ff @(posedge clk_i) begin
    if (en) begin
      n_q[0] <= -(bc_q * d2_q);
      n_q[1] <= ac_q * d2_q;
      n_q[2] <= -(ab_q * d2_q);
      n_q[3] <= ab_q * c2_q;
      for (int k = 0; k < 4; k++) begin
        e3_q[k] <= rdata[BANK_SEL_W'(base_lo2_q + BANK_SEL_W'(k))];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: rounded magnitude scaling. Outer weights divide by 6*2^18:
  // shift by 19 here, divide by three next stage.
  // ---------------------------------------------------------------------
  logic [53:0] n_mag [4];
  logic [53:0] n_rnd [4];
  logic [31:0] qpre_q [4];
  logic [3:0]  neg_q;
  logic [31:0] e4_q [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      n_mag[k] = n_q[k][53] ? 54'(-n_q[k]) : 54'(n_q[k]);
      if (k == 0 || k == 3) begin
        n_rnd[k] = (n_mag[k] + 54'(3 << 18)) >> 19;
      end else begin
        n_rnd[k] = (n_mag[k] + 54'(1 << 18)) >> 19;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        qpre_q[k] <= n_rnd[k][31:0];
        neg_q[k]  <= n_q[k][53];
        e4_q[k]   <= e3_q[k];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage 5: signed Q2.30 weights
  // ---------------------------------------------------------------------
  logic [59:0]        div3_prod [4];
  logic [31:0]        w_mag [4];
  logic signed [31:0] w_q [4];
  logic [31:0]        e5_q [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      div3_prod[k] = qpre_q[k][29:0] * DIV3_MUL;
      if (k == 0 || k == 3) begin
        w_mag[k] = 32'(div3_prod[k][59:31]);
      end else begin
        w_mag[k] = qpre_q[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        w_q[k]  <= neg_q[k] ? -$signed(w_mag[k]) : $signed(w_mag[k]);
        e5_q[k] <= e4_q[k];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage 6: weight times sample; stages 7 and 8: adder tree
  // ---------------------------------------------------------------------
  logic signed [63:0] p_q [4];
  logic signed [64:0] s01_q, s23_q;
  logic signed [65:0] acc_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        p_q[k] <= w_q[k] * $signed(e5_q[k]);
      end
      s01_q <= 65'(p_q[0]) + 65'(p_q[1]);
      s23_q <= 65'(p_q[2]) + 65'(p_q[3]);
      acc_q <= 66'(s01_q) + 66'(s23_q);
    end
  end

  // ---------------------------------------------------------------------
  // Output: round to nearest (ties away from zero), saturate, register
  // ---------------------------------------------------------------------
  logic signed [65:0] acc_rnd;
  logic signed [35:0] res_r;
  logic        [31:0] res_sat;
  logic        [31:0] value_q;
  logic               oor_q;

  // negative sums take one less bias so ties round away from zero
  assign acc_rnd = acc_q + (acc_q[65] ? 66'sd536870911 : 66'sd536870912);
  assign res_r   = 36'(acc_rnd >>> 30);

  always_comb begin
    if (res_r > 36'sd2147483647) begin
      res_sat = 32'h7FFF_FFFF;
    end else if (res_r < -36'sd2147483648) begin
      res_sat = 32'h8000_0000;
    end else begin
      res_sat = res_r[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      value_q <= (ctrl_q[PIPE_STAGES-1].eval && !ctrl_q[PIPE_STAGES-1].oor)
               ? res_sat : 32'd0;
      oor_q   <= ctrl_q[PIPE_STAGES-1].eval && ctrl_q[PIPE_STAGES-1].oor;
    end
  end

  assign m_tvalid   = out_valid_q;
  assign m_tdata    = value_q;
  assign m_tuser[0] = oor_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `TCLI_ASSERT(a_oor_zero, (m_tvalid && m_tuser[0]) |-> (m_tdata == 32'd0), "oor result not zero")
  `TCLI_ASSERT_NEXT(a_stall_hold, !en, $stable(pipe_vld), "pipeline moved while stalled")
  `TCLI_ASSERT(a_we_single, (|bank_we) |-> (accept && $onehot0(bank_we)), "bad table write")

endmodule
